### hdl/cps_pkg.sv
// Shared types, constants and tables for the cart-pole dynamics step block.
// Holds the fixed-point constants, the CORDIC arctangent table and the step micro-program.
// No dependencies.
package cps_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int CNT_W     = 16;
    localparam int FRAC_BITS = 16;
    localparam int DQ_W      = DATA_W + FRAC_BITS;
    localparam int ANG_W     = 36;
    localparam int MAG_W     = DATA_W + 30 - FRAC_BITS;
    localparam int CS_SHIFT  = 30 - FRAC_BITS;

    localparam logic [CNT_W-1:0] STEP_LIMIT_DEF = 16'd500;

    localparam int CORDIC_ITERS = 30;
    localparam int RED_STEPS    = 13;

    localparam logic signed [ANG_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] Q30_GAIN    = 36'sd652032874;

    localparam logic signed [DATA_W-1:0] FOUR_THIRDS = DATA_W'((4 << FRAC_BITS) / 3);
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    // Register reset values.
    localparam logic [CFG_W-1:0] RST_PUSH_FORCE   = 31'd655360;
    localparam logic [CFG_W-1:0] RST_CART_MASS    = 31'd65536;
    localparam logic [CFG_W-1:0] RST_POLE_MASS    = 31'd6554;
    localparam logic [CFG_W-1:0] RST_HALF_LEN     = 31'd32768;
    localparam logic [CFG_W-1:0] RST_GRAVITY      = 31'd642253;
    localparam logic [CFG_W-1:0] RST_TIME_STEP    = 31'd1311;
    localparam logic [CFG_W-1:0] RST_ANGLE_LIMIT  = 31'd13726;
    localparam logic [CFG_W-1:0] RST_POS_LIMIT    = 31'd157286;

    // Register indexes.
    localparam logic [2:0] REG_PUSH_FORCE  = 3'd0;
    localparam logic [2:0] REG_CART_MASS   = 3'd1;
    localparam logic [2:0] REG_POLE_MASS   = 3'd2;
    localparam logic [2:0] REG_HALF_LEN    = 3'd3;
    localparam logic [2:0] REG_GRAVITY     = 3'd4;
    localparam logic [2:0] REG_TIME_STEP   = 3'd5;
    localparam logic [2:0] REG_ANGLE_LIMIT = 3'd6;
    localparam logic [2:0] REG_POS_LIMIT   = 3'd7;

    // Datapath operations.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Operand sources.
    localparam logic [4:0] SRC_POS   = 5'd0;
    localparam logic [4:0] SRC_VEL   = 5'd1;
    localparam logic [4:0] SRC_ANG   = 5'd2;
    localparam logic [4:0] SRC_AVEL  = 5'd3;
    localparam logic [4:0] SRC_SN    = 5'd4;
    localparam logic [4:0] SRC_CS    = 5'd5;
    localparam logic [4:0] SRC_TOT   = 5'd6;
    localparam logic [4:0] SRC_PML   = 5'd7;
    localparam logic [4:0] SRC_TEMP  = 5'd8;
    localparam logic [4:0] SRC_NUM2  = 5'd9;
    localparam logic [4:0] SRC_ALPHA = 5'd10;
    localparam logic [4:0] SRC_ACC   = 5'd11;
    localparam logic [4:0] SRC_FORCE = 5'd12;
    localparam logic [4:0] SRC_PMASS = 5'd13;
    localparam logic [4:0] SRC_HLEN  = 5'd14;
    localparam logic [4:0] SRC_GRAV  = 5'd15;
    localparam logic [4:0] SRC_DT    = 5'd16;
    localparam logic [4:0] SRC_FT    = 5'd17;
    localparam logic [4:0] SRC_CMASS = 5'd18;

    // Result destinations.
    localparam logic [3:0] DST_TOT   = 4'd0;
    localparam logic [3:0] DST_PML   = 4'd1;
    localparam logic [3:0] DST_ACC   = 4'd2;
    localparam logic [3:0] DST_TEMP  = 4'd3;
    localparam logic [3:0] DST_NUM2  = 4'd4;
    localparam logic [3:0] DST_ALPHA = 4'd5;
    localparam logic [3:0] DST_VEL   = 4'd6;
    localparam logic [3:0] DST_POS   = 4'd7;
    localparam logic [3:0] DST_AVEL  = 4'd8;
    localparam logic [3:0] DST_ANG   = 4'd9;

    localparam logic [4:0] PROG_LAST = 5'd27;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [3:0] dst;
    } t_uop;

    typedef struct packed {
        logic accept;
        logic cordic_go;
        logic op_go;
        t_uop uop;
        logic finish;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic cor_done;
        logic op_done;
        logic finished;
        logic out_free;
    } t_stat;

    function automatic logic signed [DATA_W-1:0] cps_sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > $signed({S32_MAX[DATA_W-1], S32_MAX})) begin
            r = S32_MAX;
        end else if (v < $signed({S32_MIN[DATA_W-1], S32_MIN})) begin
            r = S32_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] cps_sat64(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = S32_MAX;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = S32_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ANG_W-1:0] cps_atan(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            5'd0:  r = 36'sd843314856;
            5'd1:  r = 36'sd497837829;
            5'd2:  r = 36'sd263043836;
            5'd3:  r = 36'sd133525158;
            5'd4:  r = 36'sd67021686;
            5'd5:  r = 36'sd33543515;
            5'd6:  r = 36'sd16775850;
            5'd7:  r = 36'sd8388437;
            5'd8:  r = 36'sd4194282;
            5'd9:  r = 36'sd2097149;
            5'd10: r = 36'sd1048575;
            5'd11: r = 36'sd524287;
            5'd12: r = 36'sd262143;
            5'd13: r = 36'sd131071;
            5'd14: r = 36'sd65535;
            5'd15: r = 36'sd32767;
            5'd16: r = 36'sd16383;
            5'd17: r = 36'sd8191;
            5'd18: r = 36'sd4095;
            5'd19: r = 36'sd2047;
            5'd20: r = 36'sd1023;
            5'd21: r = 36'sd511;
            5'd22: r = 36'sd255;
            5'd23: r = 36'sd127;
            5'd24: r = 36'sd63;
            5'd25: r = 36'sd31;
            5'd26: r = 36'sd15;
            5'd27: r = 36'sd8;
            5'd28: r = 36'sd4;
            5'd29: r = 36'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_uop mk(input logic [1:0] op, input logic [4:0] a,
                                input logic [4:0] b, input logic [3:0] d);
        t_uop u;
        u.op = op;
        u.src_a = a;
        u.src_b = b;
        u.dst = d;
        return u;
    endfunction

    // One simulation step after sin and cos are known.
    function automatic t_uop cps_prog(input logic [4:0] pc);
        t_uop u;
        unique case (pc)
            5'd0:  u = mk(OP_ADD, SRC_CMASS, SRC_PMASS, DST_TOT);
            5'd1:  u = mk(OP_MUL, SRC_PMASS, SRC_HLEN,  DST_PML);
            5'd2:  u = mk(OP_MUL, SRC_AVEL,  SRC_AVEL,  DST_ACC);
            5'd3:  u = mk(OP_MUL, SRC_PML,   SRC_ACC,   DST_ACC);
            5'd4:  u = mk(OP_MUL, SRC_ACC,   SRC_SN,    DST_ACC);
            5'd5:  u = mk(OP_ADD, SRC_FORCE, SRC_ACC,   DST_ACC);
            5'd6:  u = mk(OP_DIV, SRC_ACC,   SRC_TOT,   DST_TEMP);
            5'd7:  u = mk(OP_MUL, SRC_GRAV,  SRC_SN,    DST_NUM2);
            5'd8:  u = mk(OP_MUL, SRC_CS,    SRC_TEMP,  DST_ACC);
            5'd9:  u = mk(OP_SUB, SRC_NUM2,  SRC_ACC,   DST_NUM2);
            5'd10: u = mk(OP_MUL, SRC_CS,    SRC_CS,    DST_ACC);
            5'd11: u = mk(OP_MUL, SRC_PMASS, SRC_ACC,   DST_ACC);
            5'd12: u = mk(OP_DIV, SRC_ACC,   SRC_TOT,   DST_ACC);
            5'd13: u = mk(OP_SUB, SRC_FT,    SRC_ACC,   DST_ACC);
            5'd14: u = mk(OP_MUL, SRC_HLEN,  SRC_ACC,   DST_ACC);
            5'd15: u = mk(OP_DIV, SRC_NUM2,  SRC_ACC,   DST_ALPHA);
            5'd16: u = mk(OP_MUL, SRC_PML,   SRC_ALPHA, DST_ACC);
            5'd17: u = mk(OP_MUL, SRC_ACC,   SRC_CS,    DST_ACC);
            5'd18: u = mk(OP_DIV, SRC_ACC,   SRC_TOT,   DST_ACC);
            5'd19: u = mk(OP_SUB, SRC_TEMP,  SRC_ACC,   DST_ACC);
            5'd20: u = mk(OP_MUL, SRC_ACC,   SRC_DT,    DST_ACC);
            5'd21: u = mk(OP_ADD, SRC_VEL,   SRC_ACC,   DST_VEL);
            5'd22: u = mk(OP_MUL, SRC_VEL,   SRC_DT,    DST_ACC);
            5'd23: u = mk(OP_ADD, SRC_POS,   SRC_ACC,   DST_POS);
            5'd24: u = mk(OP_MUL, SRC_ALPHA, SRC_DT,    DST_ACC);
            5'd25: u = mk(OP_ADD, SRC_AVEL,  SRC_ACC,   DST_AVEL);
            5'd26: u = mk(OP_MUL, SRC_AVEL,  SRC_DT,    DST_ACC);
            5'd27: u = mk(OP_ADD, SRC_ANG,   SRC_ACC,   DST_ANG);
            default: u = mk(OP_ADD, SRC_ACC, SRC_ACC, DST_ACC);
        endcase
        return u;
    endfunction

endpackage

### hdl/cart_pole_dynamics_step.sv
// Top level of the cart-pole dynamics step block.
// Depends on cps_pkg, cps_ctrl and cps_dp.
//
//  channel   handshake                   payload
//  input     i_in_valid / o_in_stall     i_req_type, i_action, i_init_*
//  output    o_out_valid / i_out_stall   o_obs_*, o_steps_taken, o_episode_over, o_status
//  config    i_cfg_wr_en                 i_cfg_index, i_cfg_data
//
// A load or a rejected step goes from accept straight to publish. A simulation step runs
// through accept, a CORDIC, 28 micro-operations on one shared datapath (the four divisions
// in the bit-serial divider, fifteen multiplies and nine adds or subtracts), then finish
// and publish.
// Reset is synchronous and active low; it restores the register defaults and zero state.
// One item is worked on at a time; a new beat is taken while the last result waits, and
// publishing waits while a stalled result still holds the output register.
module cart_pole_dynamics_step #(
    parameter logic [15:0] STEP_LIMIT = cps_pkg::STEP_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic               i_action,
    input  logic signed [31:0] i_init_position,
    input  logic signed [31:0] i_init_velocity,
    input  logic signed [31:0] i_init_angle,
    input  logic signed [31:0] i_init_angular_velocity,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_obs_position,
    output logic signed [31:0] o_obs_velocity,
    output logic signed [31:0] o_obs_angle,
    output logic signed [31:0] o_obs_angular_velocity,
    output logic [15:0]        o_steps_taken,
    output logic               o_episode_over,
    output logic               o_status
);

    cps_pkg::t_cmd  cmd;
    cps_pkg::t_stat stat;

    cps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cps_dp #(
        .STEP_LIMIT (STEP_LIMIT)
    ) u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_wr_en             (i_cfg_wr_en),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_req_type              (i_req_type),
        .i_action                (i_action),
        .i_init_position         (i_init_position),
        .i_init_velocity         (i_init_velocity),
        .i_init_angle            (i_init_angle),
        .i_init_angular_velocity (i_init_angular_velocity),
        .i_out_stall             (i_out_stall),
        .o_out_valid             (o_out_valid),
        .o_obs_position          (o_obs_position),
        .o_obs_velocity          (o_obs_velocity),
        .o_obs_angle             (o_obs_angle),
        .o_obs_angular_velocity  (o_obs_angular_velocity),
        .o_steps_taken           (o_steps_taken),
        .o_episode_over          (o_episode_over),
        .o_status                (o_status),
        .i_cmd                   (cmd),
        .o_stat                  (stat)
    );

endmodule

### hdl/cps_ctrl.sv
// Sequencer for the cart-pole step: accepts beats, runs CORDIC and the micro-program.
// Depends on cps_pkg for the command and status structs and the program table.
module cps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    output logic           o_in_stall,
    input  cps_pkg::t_stat i_stat,
    output cps_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CORD  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_PUB   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [4:0] r_pc, n_pc;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_pc = r_pc;
        o_cmd = '0;
        o_cmd.uop = cps_pkg::cps_prog(r_pc);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_req_type && !i_stat.finished) begin
                        o_cmd.cordic_go = 1'b1;
                        n_state = S_CORD;
                    end else begin
                        n_state = S_PUB;
                    end
                end
            end
            S_CORD: begin
                if (i_stat.cor_done) begin
                    n_pc = '0;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.op_go = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.op_done) begin
                    if (r_pc == cps_pkg::PROG_LAST) begin
                        n_state = S_FIN;
                    end else begin
                        n_pc = r_pc + 5'd1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_PUB;
            end
            S_PUB: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc <= '0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc;
        end
    end

endmodule

### hdl/cps_dp.sv
// Datapath for the cart-pole step: state, registers, multiplier, divider, CORDIC.
// Depends on cps_pkg; driven by cps_ctrl through command and status structs.
module cps_dp #(
    parameter logic [15:0] STEP_LIMIT = cps_pkg::STEP_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_req_type,
    input  logic               i_action,
    input  logic signed [31:0] i_init_position,
    input  logic signed [31:0] i_init_velocity,
    input  logic signed [31:0] i_init_angle,
    input  logic signed [31:0] i_init_angular_velocity,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [31:0] o_obs_position,
    output logic signed [31:0] o_obs_velocity,
    output logic signed [31:0] o_obs_angle,
    output logic signed [31:0] o_obs_angular_velocity,
    output logic [15:0]        o_steps_taken,
    output logic               o_episode_over,
    output logic               o_status,
    input  cps_pkg::t_cmd      i_cmd,
    output cps_pkg::t_stat     o_stat
);

    localparam int DW = cps_pkg::DATA_W;
    localparam int AW = cps_pkg::ANG_W;
    localparam int QW = cps_pkg::DQ_W;
    localparam int MW = cps_pkg::MAG_W;

    localparam logic [1:0] CP_RED  = 2'd0;
    localparam logic [1:0] CP_FOLD = 2'd1;
    localparam logic [1:0] CP_ROT  = 2'd2;
    localparam logic [1:0] CP_OUT  = 2'd3;

    localparam logic [QW-1:0] DQ_MIN_MAG = QW'(64'h8000_0000);
    localparam logic [QW-1:0] DQ_MAX_MAG = QW'(64'h7FFF_FFFF);
    localparam logic [5:0]    DIV_ITERS  = 6'(QW);
    localparam logic [4:0]    RED_TOP    = 5'(cps_pkg::RED_STEPS - 1);
    localparam logic [4:0]    ROT_LAST   = 5'(cps_pkg::CORDIC_ITERS - 1);

    // Configuration.
    logic [30:0] r_push, r_cmass, r_pmass, r_hlen, r_grav, r_dt, r_alim, r_plim;

    // Simulation state and scratch.
    logic signed [DW-1:0] r_pos, r_vel, r_ang, r_avel;
    logic [15:0]          r_cnt;
    logic                 r_flag;
    logic                 r_action, r_status;
    logic signed [DW-1:0] r_sn, r_cs, r_tot, r_pml, r_temp, r_num2, r_alpha, r_acc;

    // Output register.
    logic                 r_out_valid;
    logic signed [DW-1:0] r_out_pos, r_out_vel, r_out_ang, r_out_avel;
    logic [15:0]          r_out_cnt;
    logic                 r_out_flag, r_out_status;

    // Multiplier.
    logic signed [63:0] r_prod;
    logic               r_mul_busy;
    logic [3:0]         r_dst;
    logic               r_op_done;

    // Divider.
    logic               r_div_busy;
    logic [5:0]         r_dcnt;
    logic [QW-1:0]      r_dq;
    logic [DW:0]        r_drem;
    logic [DW-1:0]      r_dd;
    logic               r_dneg, r_dzero, r_dapos, r_daneg;

    // CORDIC.
    logic               r_cbusy, r_cor_done, r_cneg, r_cflip;
    logic [1:0]         r_cph;
    logic [4:0]         r_ck;
    logic [MW-1:0]      r_cm;
    logic signed [AW-1:0] r_cx, r_cy, r_cz;

    function automatic logic signed [DW-1:0] f_pick(input logic [4:0] sel);
        logic signed [DW-1:0] v;
        case (sel)
            cps_pkg::SRC_POS:   v = r_pos;
            cps_pkg::SRC_VEL:   v = r_vel;
            cps_pkg::SRC_ANG:   v = r_ang;
            cps_pkg::SRC_AVEL:  v = r_avel;
            cps_pkg::SRC_SN:    v = r_sn;
            cps_pkg::SRC_CS:    v = r_cs;
            cps_pkg::SRC_TOT:   v = r_tot;
            cps_pkg::SRC_PML:   v = r_pml;
            cps_pkg::SRC_TEMP:  v = r_temp;
            cps_pkg::SRC_NUM2:  v = r_num2;
            cps_pkg::SRC_ALPHA: v = r_alpha;
            cps_pkg::SRC_ACC:   v = r_acc;
            cps_pkg::SRC_FORCE: v = r_action ? $signed({1'b0, r_push}) : -$signed({1'b0, r_push});
            cps_pkg::SRC_PMASS: v = $signed({1'b0, r_pmass});
            cps_pkg::SRC_HLEN:  v = $signed({1'b0, r_hlen});
            cps_pkg::SRC_GRAV:  v = $signed({1'b0, r_grav});
            cps_pkg::SRC_DT:    v = $signed({1'b0, r_dt});
            cps_pkg::SRC_FT:    v = cps_pkg::FOUR_THIRDS;
            cps_pkg::SRC_CMASS: v = $signed({1'b0, r_cmass});
            default:            v = '0;
        endcase
        return v;
    endfunction

    logic signed [DW-1:0] op_a, op_b;
    logic [DW-1:0]        abs_a, abs_b;
    logic signed [DW:0]   addsub;
    logic                 add_go, mul_go, div_go;
    logic                 wb_en;
    logic [3:0]           wb_dst;
    logic signed [DW-1:0] wb_data, div_res;
    logic signed [63:0]   prod_sh;
    logic [DW:0]          rem_sh;
    logic                 rem_ge;

    assign op_a = f_pick(i_cmd.uop.src_a);
    assign op_b = f_pick(i_cmd.uop.src_b);
    assign abs_a = op_a[DW-1] ? DW'(-op_a) : DW'(op_a);
    assign abs_b = op_b[DW-1] ? DW'(-op_b) : DW'(op_b);
    assign add_go = i_cmd.op_go && (i_cmd.uop.op == cps_pkg::OP_ADD ||
                                    i_cmd.uop.op == cps_pkg::OP_SUB);
    assign mul_go = i_cmd.op_go && (i_cmd.uop.op == cps_pkg::OP_MUL);
    assign div_go = i_cmd.op_go && (i_cmd.uop.op == cps_pkg::OP_DIV);
    assign addsub = (i_cmd.uop.op == cps_pkg::OP_SUB) ?
                    ($signed({op_a[DW-1], op_a}) - $signed({op_b[DW-1], op_b})) :
                    ($signed({op_a[DW-1], op_a}) + $signed({op_b[DW-1], op_b}));
    assign prod_sh = r_prod >>> cps_pkg::FRAC_BITS;
    assign rem_sh = {r_drem[DW-1:0], r_dq[QW-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dd};

    always_comb begin
        if (r_dzero) begin
            div_res = r_dapos ? cps_pkg::S32_MAX : (r_daneg ? cps_pkg::S32_MIN : '0);
        end else if (r_dneg) begin
            div_res = (r_dq > DQ_MIN_MAG) ? cps_pkg::S32_MIN : -$signed(r_dq[DW-1:0]);
        end else begin
            div_res = (r_dq > DQ_MAX_MAG) ? cps_pkg::S32_MAX : $signed(r_dq[DW-1:0]);
        end
    end

    always_comb begin
        wb_en = 1'b0;
        wb_dst = r_dst;
        wb_data = cps_pkg::cps_sat64(prod_sh);
        if (add_go) begin
            wb_en = 1'b1;
            wb_dst = i_cmd.uop.dst;
            wb_data = cps_pkg::cps_sat33(addsub);
        end else if (r_mul_busy) begin
            wb_en = 1'b1;
        end else if (r_div_busy && r_dcnt == '0) begin
            wb_en = 1'b1;
            wb_data = div_res;
        end
    end

    // CORDIC range reduction and rotation terms.
    logic [MW-1:0]        red_sub;
    logic signed [AW-1:0] f_r0, f_r1, f_r2, f_r3, xs, ys, xf, yf, sh_y, sh_x;
    logic                 f_flip;

    assign red_sub = MW'(cps_pkg::Q30_TWO_PI) << r_ck;
    assign f_r0 = r_cneg ? -$signed({1'b0, r_cm[AW-2:0]}) : $signed({1'b0, r_cm[AW-2:0]});

    always_comb begin
        f_r1 = f_r0;
        if (f_r1 > cps_pkg::Q30_PI) f_r1 = f_r1 - cps_pkg::Q30_TWO_PI;
        f_r2 = f_r1;
        if (f_r2 < -cps_pkg::Q30_PI) f_r2 = f_r2 + cps_pkg::Q30_TWO_PI;
        f_flip = 1'b0;
        f_r3 = f_r2;
        if (f_r2 > cps_pkg::Q30_HALF_PI) begin
            f_r3 = f_r2 - cps_pkg::Q30_PI;
            f_flip = 1'b1;
        end else if (f_r2 < -cps_pkg::Q30_HALF_PI) begin
            f_r3 = f_r2 + cps_pkg::Q30_PI;
            f_flip = 1'b1;
        end
    end

    assign ys = r_cy >>> r_ck;
    assign xs = r_cx >>> r_ck;
    assign xf = r_cflip ? -r_cx : r_cx;
    assign yf = r_cflip ? -r_cy : r_cy;
    assign sh_y = yf >>> cps_pkg::CS_SHIFT;
    assign sh_x = xf >>> cps_pkg::CS_SHIFT;

    // Episode bookkeeping for the end of a step.
    logic [15:0] n_cnt;
    logic [DW-1:0] abs_ang, abs_pos;
    assign n_cnt = (r_cnt == 16'hFFFF) ? r_cnt : r_cnt + 16'd1;
    assign abs_ang = r_ang[DW-1] ? DW'(-r_ang) : DW'(r_ang);
    assign abs_pos = r_pos[DW-1] ? DW'(-r_pos) : DW'(r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push <= cps_pkg::RST_PUSH_FORCE;
            r_cmass <= cps_pkg::RST_CART_MASS;
            r_pmass <= cps_pkg::RST_POLE_MASS;
            r_hlen <= cps_pkg::RST_HALF_LEN;
            r_grav <= cps_pkg::RST_GRAVITY;
            r_dt <= cps_pkg::RST_TIME_STEP;
            r_alim <= cps_pkg::RST_ANGLE_LIMIT;
            r_plim <= cps_pkg::RST_POS_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                cps_pkg::REG_PUSH_FORCE:  r_push <= i_cfg_data;
                cps_pkg::REG_CART_MASS:   r_cmass <= i_cfg_data;
                cps_pkg::REG_POLE_MASS:   r_pmass <= i_cfg_data;
                cps_pkg::REG_HALF_LEN:    r_hlen <= i_cfg_data;
                cps_pkg::REG_GRAVITY:     r_grav <= i_cfg_data;
                cps_pkg::REG_TIME_STEP:   r_dt <= i_cfg_data;
                cps_pkg::REG_ANGLE_LIMIT: r_alim <= i_cfg_data;
                cps_pkg::REG_POS_LIMIT:   r_plim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // State and scratch registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vel <= '0;
            r_ang <= '0;
            r_avel <= '0;
            r_cnt <= '0;
            r_flag <= 1'b0;
            r_status <= 1'b0;
            r_action <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_action <= i_action;
                r_status <= i_req_type & r_flag;
                if (!i_req_type) begin
                    r_pos <= i_init_position;
                    r_vel <= i_init_velocity;
                    r_ang <= i_init_angle;
                    r_avel <= i_init_angular_velocity;
                    r_cnt <= '0;
                    r_flag <= 1'b0;
                end
            end
            if (wb_en) begin
                case (wb_dst)
                    cps_pkg::DST_VEL:  r_vel <= wb_data;
                    cps_pkg::DST_POS:  r_pos <= wb_data;
                    cps_pkg::DST_AVEL: r_avel <= wb_data;
                    cps_pkg::DST_ANG:  r_ang <= wb_data;
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_cnt <= n_cnt;
                r_flag <= (abs_ang > {1'b0, r_alim}) || (abs_pos > {1'b0, r_plim}) ||
                          (n_cnt >= STEP_LIMIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_en) begin
            case (wb_dst)
                cps_pkg::DST_TOT:   r_tot <= wb_data;
                cps_pkg::DST_PML:   r_pml <= wb_data;
                cps_pkg::DST_ACC:   r_acc <= wb_data;
                cps_pkg::DST_TEMP:  r_temp <= wb_data;
                cps_pkg::DST_NUM2:  r_num2 <= wb_data;
                cps_pkg::DST_ALPHA: r_alpha <= wb_data;
                default: ;
            endcase
        end
        if (r_cbusy && r_cph == CP_OUT) begin
            r_sn <= sh_y[DW-1:0];
            r_cs <= sh_x[DW-1:0];
        end
    end

    // Multiplier and divider sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_div_busy <= 1'b0;
            r_op_done <= 1'b0;
        end else begin
            r_op_done <= wb_en;
            r_mul_busy <= mul_go;
            if (div_go) begin
                r_div_busy <= 1'b1;
            end else if (r_div_busy && r_dcnt == '0) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_go) begin
            r_prod <= 64'(op_a) * 64'(op_b);
            r_dst <= i_cmd.uop.dst;
        end
        if (div_go) begin
            r_dst <= i_cmd.uop.dst;
            r_dq <= {abs_a, {cps_pkg::FRAC_BITS{1'b0}}};
            r_drem <= '0;
            r_dd <= abs_b;
            r_dcnt <= DIV_ITERS;
            r_dneg <= op_a[DW-1] ^ op_b[DW-1];
            r_dzero <= (op_b == '0);
            r_dapos <= !op_a[DW-1] && (op_a != '0);
            r_daneg <= op_a[DW-1];
        end else if (r_div_busy && r_dcnt != '0) begin
            // Restoring division, one quotient bit per cycle.
            r_drem <= rem_ge ? rem_sh - {1'b0, r_dd} : rem_sh;
            r_dq <= {r_dq[QW-2:0], rem_ge};
            r_dcnt <= r_dcnt - 6'd1;
        end
    end

    // CORDIC: reduce modulo two pi by shifted subtraction, fold, then rotate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbusy <= 1'b0;
            r_cor_done <= 1'b0;
            r_cph <= CP_RED;
        end else begin
            r_cor_done <= 1'b0;
            if (i_cmd.cordic_go) begin
                r_cbusy <= 1'b1;
                r_cph <= CP_RED;
            end else if (r_cbusy) begin
                case (r_cph)
                    CP_RED:  if (r_ck == '0) r_cph <= CP_FOLD;
                    CP_FOLD: r_cph <= CP_ROT;
                    CP_ROT:  if (r_ck == ROT_LAST) r_cph <= CP_OUT;
                    default: begin
                        r_cbusy <= 1'b0;
                        r_cor_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_go) begin
            r_cm <= {(r_ang[DW-1] ? DW'(-r_ang) : DW'(r_ang)),
                     {cps_pkg::CS_SHIFT{1'b0}}};
            r_cneg <= r_ang[DW-1];
            r_ck <= RED_TOP;
        end else if (r_cbusy) begin
            case (r_cph)
                CP_RED: begin
                    if (r_cm >= red_sub) r_cm <= r_cm - red_sub;
                    if (r_ck != '0) r_ck <= r_ck - 5'd1;
                end
                CP_FOLD: begin
                    r_cz <= f_r3;
                    r_cflip <= f_flip;
                    r_cx <= cps_pkg::Q30_GAIN;
                    r_cy <= '0;
                    r_ck <= '0;
                end
                CP_ROT: begin
                    if (!r_cz[AW-1]) begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_cz <= r_cz - cps_pkg::cps_atan(r_ck);
                    end else begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_cz <= r_cz + cps_pkg::cps_atan(r_ck);
                    end
                    if (r_ck != ROT_LAST) r_ck <= r_ck + 5'd1;
                end
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_pos <= r_pos;
            r_out_vel <= r_vel;
            r_out_ang <= r_ang;
            r_out_avel <= r_avel;
            r_out_cnt <= r_cnt;
            r_out_flag <= r_flag;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_obs_position = r_out_pos;
    assign o_obs_velocity = r_out_vel;
    assign o_obs_angle = r_out_ang;
    assign o_obs_angular_velocity = r_out_avel;
    assign o_steps_taken = r_out_cnt;
    assign o_episode_over = r_out_flag;
    assign o_status = r_out_status;

    assign o_stat.cor_done = r_cor_done;
    assign o_stat.op_done = r_op_done;
    assign o_stat.finished = r_flag;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

endmodule
